FILE: hw/rtl/mmc_pkg.sv
// Shared constants, configuration and controller/datapath interface types.
package mmc_pkg;

    localparam int AXES    = 3;
    localparam int SMP_W   = 16;
    localparam int ADJ_W   = 8;
    localparam int K_W     = 9;
    localparam int THR_W   = 15;
    localparam int CNT_W   = 16;
    localparam int PROD_W  = 26;
    localparam int EXT_W   = SMP_W + 1;
    localparam int QFRAC   = 12;
    localparam int DIV_NW  = EXT_W + QFRAC;
    localparam int DIV_DW  = EXT_W;
    localparam int DIV_CW  = $clog2(DIV_NW);
    localparam int AX_W    = $clog2(AXES);
    localparam int IDX_W   = 3;
    localparam int CFG_DW  = 16;
    localparam int IN_W    = AXES * SMP_W;
    localparam int OUT_W   = 2 * AXES * SMP_W;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ADJ_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_ADJ_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ADJ_Z     = 3'd2;
    localparam logic [IDX_W-1:0] REG_FILTER_K  = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd4;
    localparam logic [IDX_W-1:0] REG_REQUIRED  = 3'd5;

    localparam logic [ADJ_W-1:0] ADJ_RST = 8'd128;
    localparam logic [K_W-1:0]   K_RST   = 9'd4;
    localparam logic [THR_W-1:0] THR_RST = 15'd16;
    localparam logic [CNT_W-1:0] REQ_RST = 16'd1000;
    localparam logic [K_W-1:0]   GAIN_OFS = 9'd128;
    localparam logic [SMP_W-1:0] SCALE_SAT = 16'hFFFF;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;
    localparam logic [AX_W-1:0]  AX_LAST   = 2'd2;

    typedef struct packed {
        logic [AXES-1:0][ADJ_W-1:0] adj;
        logic [K_W-1:0]             k;
        logic [THR_W-1:0]           thr;
        logic [CNT_W-1:0]           need;
    } cfg_t;

    typedef struct packed {
        logic            load_raw;
        logic            scale;
        logic            seed;
        logic            fmul;
        logic            fdiv_start;
        logic            fupd;
        logic            cnt_upd;
        logic            half;
        logic            sum;
        logic            qdiv_start;
        logic            qupd;
        logic            emit;
        logic [AX_W-1:0] ax;
    } cmd_t;

    typedef struct packed {
        logic run_started;
        logic div_done;
        logic count_reached;
        logic half_zero;
    } sts_t;

endpackage

FILE: hw/rtl/mmc_div.sv
// Restoring divider, one quotient bit per cycle, shared by filter and scale.
module mmc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mmc_pkg::DIV_NW-1:0] dividend,
    input  logic [mmc_pkg::DIV_DW-1:0] divisor,
    output logic [mmc_pkg::DIV_NW-1:0] quotient,
    output logic                       busy,
    output logic                       done
);
    import mmc_pkg::*;

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    // top bit set means the trial remainder is below the divisor
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[DIV_DW] ? trial[DIV_DW-1:0] : diff[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], ~diff[DIV_DW]};
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

FILE: hw/rtl/mmc_datapath.sv
// Datapath: sample scaling, IIR filters, min/max tracking, stable count and results.
module mmc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mmc_pkg::cfg_t             cfg,
    input  logic [mmc_pkg::IN_W-1:0]  in_data,   // mag_x, mag_y, mag_z
    input  mmc_pkg::cmd_t             cmd,
    output mmc_pkg::sts_t             sts,
    output logic [mmc_pkg::OUT_W-1:0] res_data   // bias_x..z, scale_x..z
);
    import mmc_pkg::*;

    logic [AXES-1:0][SMP_W-1:0] raw_reg;
    logic [AXES-1:0][SMP_W-1:0] smp_reg;
    logic [AXES-1:0][SMP_W-1:0] filt_reg;
    logic [AXES-1:0][SMP_W-1:0] max_reg;
    logic [AXES-1:0][SMP_W-1:0] min_reg;
    logic [AXES-1:0][SMP_W-1:0] bias_reg;
    logic [AXES-1:0][SMP_W-1:0] half_reg;
    logic [AXES-1:0][SMP_W-1:0] scale_reg;
    logic [EXT_W-1:0]           frame_reg;
    logic [EXT_W-1:0]           frame_next;
    logic [EXT_W-1:0]           sum_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       run_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   acc_next;

    // sample scaling
    logic [K_W-1:0]             gain;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic [PROD_W-9:0]          prod_q;
    logic [SMP_W-1:0]           smp_next;

    // filter
    logic [K_W-1:0]             k_eff;
    logic [K_W-1:0]             km1;
    logic signed [PROD_W-1:0]   fprod;
    logic [PROD_W-1:0]          acc_mag;
    logic [EXT_W-1:0]           f_q;
    logic [EXT_W-1:0]           f_full;
    logic [SMP_W-1:0]           f_new;
    logic [EXT_W-1:0]           d_up;
    logic [EXT_W-1:0]           d_dn;
    logic                       ext_up;
    logic                       ext_dn;

    // results
    logic [CNT_W-1:0]           need_eff;
    logic [EXT_W-1:0]           half3;
    logic [DIV_NW-1:0]          div_dividend;
    logic [DIV_DW-1:0]          div_divisor;
    logic [DIV_NW-1:0]          div_quo;
    logic                       div_busy;
    logic                       div_done;
    logic                       div_start;
    logic [SMP_W-1:0]           scale_next;

    assign gain     = {1'b0, cfg.adj[cmd.ax]} + GAIN_OFS;
    assign prod     = $signed({1'b0, gain}) * $signed(raw_reg[cmd.ax]);
    // bias negative products so the shift truncates toward zero
    assign prod_rnd = prod + $signed({{(PROD_W-8){1'b0}}, {8{prod[PROD_W-1]}}});
    assign prod_q   = prod_rnd[PROD_W-1:8];

    always_comb
    begin
        if (prod_q[PROD_W-9:SMP_W-1] == '0 || prod_q[PROD_W-9:SMP_W-1] == '1)
            smp_next = prod_q[SMP_W-1:0];
        else if (prod_q[PROD_W-9])
            smp_next = {1'b1, {(SMP_W-1){1'b0}}};
        else
            smp_next = {1'b0, {(SMP_W-1){1'b1}}};
    end

    assign k_eff    = (cfg.k == '0) ? K_W'(1) : cfg.k;
    assign km1      = k_eff - 1'b1;
    assign fprod    = $signed({1'b0, km1}) * $signed(filt_reg[cmd.ax]);
    assign acc_next = fprod + PROD_W'($signed(smp_reg[cmd.ax]));
    assign acc_mag  = acc_reg[PROD_W-1] ? PROD_W'(-acc_reg) : PROD_W'(acc_reg);

    assign f_q    = div_quo[EXT_W-1:0];
    assign f_full = acc_reg[PROD_W-1] ? (~f_q + 1'b1) : f_q;
    assign f_new  = f_full[SMP_W-1:0];

    assign ext_up = $signed(f_new) > $signed(max_reg[cmd.ax]);
    assign ext_dn = $signed(f_new) < $signed(min_reg[cmd.ax]);
    assign d_up   = {f_new[SMP_W-1], f_new}
                    - {max_reg[cmd.ax][SMP_W-1], max_reg[cmd.ax]};
    assign d_dn   = {min_reg[cmd.ax][SMP_W-1], min_reg[cmd.ax]}
                    - {f_new[SMP_W-1], f_new};

    always_comb
    begin
        frame_next = frame_reg;
        if (ext_up && d_up > frame_next)
            frame_next = d_up;
        if (ext_dn && d_dn > frame_next)
            frame_next = d_dn;
    end

    assign need_eff = (cfg.need == '0) ? CNT_W'(1) : cfg.need;
    assign half3    = {half_reg[cmd.ax], 1'b0} + EXT_W'(half_reg[cmd.ax]);

    assign div_start    = cmd.fdiv_start | cmd.qdiv_start;
    assign div_dividend = cmd.qdiv_start ? {sum_reg, {QFRAC{1'b0}}} : DIV_NW'(acc_mag);
    assign div_divisor  = cmd.qdiv_start ? half3 : DIV_DW'(k_eff);

    assign scale_next = (div_quo[DIV_NW-1:SMP_W] != '0) ? SCALE_SAT : div_quo[SMP_W-1:0];

    mmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.seed)
            begin
                count_reg <= '0;
                run_reg   <= 1'b1;
            end
            else if (cmd.emit)
            begin
                count_reg <= '0;
                run_reg   <= 1'b0;
            end
            else if (cmd.cnt_upd)
            begin
                if (frame_reg > EXT_W'(cfg.thr))
                    count_reg <= '0;
                else if (count_reg != CNT_MAX)
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_raw)
        begin
            raw_reg   <= in_data;
            frame_reg <= '0;
        end
        if (cmd.scale)
            smp_reg[cmd.ax] <= smp_next;
        if (cmd.seed)
        begin
            max_reg  <= smp_reg;
            min_reg  <= smp_reg;
            filt_reg <= '0;
        end
        if (cmd.fmul)
            acc_reg <= acc_next;
        if (cmd.fupd)
        begin
            filt_reg[cmd.ax] <= f_new;
            frame_reg        <= frame_next;
            if (ext_up)
                max_reg[cmd.ax] <= f_new;
            if (ext_dn)
                min_reg[cmd.ax] <= f_new;
        end
        if (cmd.half)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                logic [EXT_W-1:0] bsum;
                logic [EXT_W-1:0] hdiff;
                bsum  = {max_reg[i][SMP_W-1], max_reg[i]} + {min_reg[i][SMP_W-1], min_reg[i]};
                bsum  = bsum + EXT_W'(bsum[EXT_W-1]);
                hdiff = {max_reg[i][SMP_W-1], max_reg[i]} - {min_reg[i][SMP_W-1], min_reg[i]};
                bias_reg[i] <= bsum[EXT_W-1:1];
                half_reg[i] <= hdiff[EXT_W-1:1];
            end
        end
        if (cmd.sum)
            sum_reg <= EXT_W'(half_reg[0]) + EXT_W'(half_reg[1]) + EXT_W'(half_reg[2]);
        if (cmd.qupd)
            scale_reg[cmd.ax] <= (half_reg[cmd.ax] == '0) ? SCALE_SAT : scale_next;
    end

    assign sts.run_started   = run_reg;
    assign sts.div_done      = div_done;
    assign sts.count_reached = count_reg >= need_eff;
    assign sts.half_zero     = half_reg[cmd.ax] == '0;

    assign res_data = {scale_reg, bias_reg};

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> ($signed(min_reg[0]) <= $signed(max_reg[0])
                  && $signed(min_reg[1]) <= $signed(max_reg[1])
                  && $signed(min_reg[2]) <= $signed(max_reg[2])))
        else $error("axis min above max");

    a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (run_reg && sts.count_reached))
        else $error("result emitted outside a settled run");
`endif

endmodule

FILE: hw/rtl/mmc_ctrl.sv
// Controller state machine sequencing the datapath one item at a time.
module mmc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_free,
    input  mmc_pkg::sts_t sts,
    output mmc_pkg::cmd_t cmd
);
    import mmc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_SEED  = 4'd2;
    localparam logic [3:0] ST_FMUL  = 4'd3;
    localparam logic [3:0] ST_FDIV  = 4'd4;
    localparam logic [3:0] ST_FWAIT = 4'd5;
    localparam logic [3:0] ST_COUNT = 4'd6;
    localparam logic [3:0] ST_CHECK = 4'd7;
    localparam logic [3:0] ST_HALF  = 4'd8;
    localparam logic [3:0] ST_SUM   = 4'd9;
    localparam logic [3:0] ST_QDIV  = 4'd10;
    localparam logic [3:0] ST_QWAIT = 4'd11;
    localparam logic [3:0] ST_EMIT  = 4'd12;

    logic [3:0]      state_reg;
    logic [3:0]      state_next;
    logic [AX_W-1:0] ax_reg;
    logic [AX_W-1:0] ax_next;

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        cmd        = '0;
        cmd.ax     = ax_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_raw = 1'b1;
                    ax_next      = '0;
                    state_next   = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
                if (ax_reg == AX_LAST)
                begin
                    ax_next    = '0;
                    state_next = sts.run_started ? ST_FMUL : ST_SEED;
                end
                else
                    ax_next = ax_reg + 1'b1;
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FMUL:
            begin
                cmd.fmul   = 1'b1;
                state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                cmd.fdiv_start = 1'b1;
                state_next     = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.fupd = 1'b1;
                    if (ax_reg == AX_LAST)
                    begin
                        ax_next    = '0;
                        state_next = ST_COUNT;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = ST_FMUL;
                    end
                end
            end
            ST_COUNT:
            begin
                cmd.cnt_upd = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
                state_next = sts.count_reached ? ST_HALF : ST_IDLE;
            ST_HALF:
            begin
                cmd.half   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                ax_next    = '0;
                state_next = ST_QDIV;
            end
            ST_QDIV:
            begin
                // an axis with no spread saturates without a division
                if (sts.half_zero)
                begin
                    cmd.qupd = 1'b1;
                    if (ax_reg == AX_LAST)
                        state_next = ST_EMIT;
                    else
                        ax_next = ax_reg + 1'b1;
                end
                else
                begin
                    cmd.qdiv_start = 1'b1;
                    state_next     = ST_QWAIT;
                end
            end
            ST_QWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.qupd = 1'b1;
                    if (ax_reg == AX_LAST)
                        state_next = ST_EMIT;
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = ST_QDIV;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ax_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
        end
    end

`ifndef SYNTHESIS
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_FWAIT || state_reg == ST_QWAIT))
        else $error("divider finished outside a wait state");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result emitted over an untaken one");
`endif

endmodule

FILE: hw/rtl/magnetometer_minmax_calibrator.sv
// Magnetometer min/max calibrator: configuration registers, output register, top level.
//
// Input stream s_*: one item is a raw x/y/z magnetometer sample. Output stream m_*:
// one item holds the hard-iron biases and soft-iron Q4.12 scales, sent once a run
// has seen required_samples consecutive stable samples; a new run starts with the
// next input item, which only seeds min and max.
// Config port cfg_*: index 0..5 selects sens_adj_x/y/z, filter_divisor,
// settle_threshold, required_samples; always ready; write only while idle.
// Items are handled one at a time. A seeding item uses no division, an ordinary item
// runs three 29-step divisions of the shared bit-serial divider (one per axis filter),
// and an item that ends a run runs up to three scale divisions more on the same divider
// before its result reaches the output register.
// A result waits in the output register while m_tready is low; the next item is
// still taken and worked on, and only its own result, if any, waits for the
// register to empty.
// Reset (rst_n, asynchronous, active low) restores register defaults, clears the
// stable count and starts a fresh run; no clearing pass is needed.
module magnetometer_minmax_calibrator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mmc_pkg::IN_W-1:0]    s_tdata,    // mag_x, mag_y, mag_z
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mmc_pkg::OUT_W-1:0]   m_tdata,    // bias_x..z, scale_x..z
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mmc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mmc_pkg::CFG_DW-1:0]  cfg_data
);
    import mmc_pkg::*;

    cfg_t             cfg_reg;
    cmd_t             cmd;
    sts_t             sts;
    logic [OUT_W-1:0] res_data;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adj  <= {AXES{ADJ_RST}};
            cfg_reg.k    <= K_RST;
            cfg_reg.thr  <= THR_RST;
            cfg_reg.need <= REQ_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ADJ_X:     cfg_reg.adj[0] <= cfg_data[ADJ_W-1:0];
                REG_ADJ_Y:     cfg_reg.adj[1] <= cfg_data[ADJ_W-1:0];
                REG_ADJ_Z:     cfg_reg.adj[2] <= cfg_data[ADJ_W-1:0];
                REG_FILTER_K:  cfg_reg.k      <= cfg_data[K_W-1:0];
                REG_THRESHOLD: cfg_reg.thr    <= cfg_data[THR_W-1:0];
                REG_REQUIRED:  cfg_reg.need   <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_data_reg <= res_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    mmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (res_data)
    );

endmodule
